### rtl/rau_pkg.sv
package rau_pkg;

  localparam int WordBits = 32;
  localparam int MagBits  = 64;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_EQ   = 3'd5,
    OP_NE   = 3'd6,
    OP_QUO  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RED_A,
    S_RED_B,
    S_PROD,
    S_COMB,
    S_RED_R,
    S_QUO,
    S_FIN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_NONE,
    DV_GCD,
    DV_DIVN,
    DV_DIVD
  } dv_phase_t;

  typedef struct packed {
    logic load;
    logic check;
    logic red_start;
    logic [1:0] red_sel;
    logic prod;
    logic comb;
    logic quo_start;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic skip_b;
    logic is_cmp;
    logic is_neg;
    logic is_quo;
    logic done;
  } sts_t;

endpackage

### rtl/rau_divider.sv
module rau_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quot,
  output logic [63:0] rem
);

  logic [6:0]  count;
  logic [63:0] dvs;
  logic [64:0] trial;

  assign trial = {1'b0, rem[62:0], quot[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 7'd64;
    end else if (busy) begin
      count <= count - 7'd1;
      if (count == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quot[63]};
        quot <= {quot[62:0], 1'b0};
      end
    end
  end

endmodule

### rtl/rau_reducer.sv
module rau_reducer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num_in,
  input  logic [63:0] den_in,
  output logic        done,
  output logic [63:0] num_out,
  output logic [63:0] den_out
);

  rau_pkg::dv_phase_t phase;
  logic        dv_start;
  logic        dv_busy;
  logic        dv_busy_d;
  logic [63:0] dv_a;
  logic [63:0] dv_b;
  logic [63:0] dv_q;
  logic [63:0] dv_r;
  logic [63:0] gx;
  logic [63:0] gy;
  logic        dv_fin;

  assign dv_fin = dv_busy_d && !dv_busy;

  rau_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_a),
    .divisor  (dv_b),
    .busy     (dv_busy),
    .quot     (dv_q),
    .rem      (dv_r)
  );

  always_comb begin
    dv_start = 1'b0;
    dv_a = gx;
    dv_b = gy;
    unique case (phase)
      rau_pkg::DV_GCD: begin
        dv_start = dv_fin && (dv_r != '0);
        dv_a = gy;
        dv_b = dv_r;
        if (dv_fin && dv_r == '0) begin
          dv_start = 1'b1;
          dv_a = num_out;
          dv_b = gy;
        end
      end
      rau_pkg::DV_DIVN: begin
        dv_start = dv_fin;
        dv_a = den_out;
        dv_b = gx;
      end
      default: begin
        dv_start = start && (num_in != '0);
        dv_a = num_in;
        dv_b = den_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rau_pkg::DV_NONE;
      done <= 1'b0;
      dv_busy_d <= 1'b0;
    end else begin
      dv_busy_d <= dv_busy;
      done <= 1'b0;
      unique case (phase)
        rau_pkg::DV_NONE: begin
          if (start) begin
            if (num_in == '0) begin
              done <= 1'b1;
            end else begin
              phase <= rau_pkg::DV_GCD;
            end
          end
        end
        rau_pkg::DV_GCD: begin
          if (dv_fin && dv_r == '0) begin
            phase <= rau_pkg::DV_DIVN;
          end
        end
        rau_pkg::DV_DIVN: begin
          if (dv_fin) begin
            phase <= rau_pkg::DV_DIVD;
          end
        end
        default: begin
          if (dv_fin) begin
            phase <= rau_pkg::DV_NONE;
            done <= 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == rau_pkg::DV_NONE && start) begin
      gx <= num_in;
      gy <= den_in;
      num_out <= (num_in == '0) ? 64'd0 : num_in;
      den_out <= (num_in == '0) ? 64'd1 : den_in;
    end else if (phase == rau_pkg::DV_GCD && dv_fin) begin
      if (dv_r == '0) begin
        gx <= gy;
      end else begin
        gx <= gy;
        gy <= dv_r;
      end
    end else if (phase == rau_pkg::DV_DIVN && dv_fin) begin
      num_out <= dv_q;
    end else if (phase == rau_pkg::DV_DIVD && dv_fin) begin
      den_out <= dv_q;
    end
  end

endmodule

### rtl/rau_datapath.sv
module rau_datapath #(
  parameter int WORD_BITS = rau_pkg::WordBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rau_pkg::cmd_t         cmd,
  input  logic [2:0]            op,
  input  logic signed [31:0]    a_num,
  input  logic signed [31:0]    a_den,
  input  logic signed [31:0]    b_num,
  input  logic signed [31:0]    b_den,
  output rau_pkg::sts_t         sts,
  output logic signed [31:0]    res_num,
  output logic [30:0]           res_den,
  output logic                  cmp_flag,
  output logic [1:0]            status
);

  localparam logic [63:0] Lim = 64'd1 << (WORD_BITS - 1);

  logic [2:0]  op_r;
  logic [31:0] an, ad, bn, bd;
  logic        a_neg, b_neg, r_neg;
  logic [63:0] a_n, a_d, b_n, b_d;
  logic [63:0] x, y, dd, mag, rn, rd;
  logic        red_start, red_done;
  logic [63:0] red_n_in, red_d_in, red_n, red_d;
  logic [1:0]  red_tgt;
  logic        dv_start, dv_busy, dv_busy_d;
  logic [63:0] dv_q, dv_r;
  logic        sb;
  logic        fit;
  logic        uses_b;
  logic [63:0] comb_n;
  logic        comb_neg;

  function automatic logic [63:0] mag32(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (32'd0 - v) : v;
    return {32'd0, (v == 32'h8000_0000) ? 32'h8000_0000 : m};
  endfunction

  function automatic logic [63:0] mul32(input logic [31:0] p, input logic [31:0] q);
    return 64'(p) * 64'(q);
  endfunction

  assign uses_b = (op_r != rau_pkg::OP_NEG) && (op_r != rau_pkg::OP_QUO);

  always_comb begin
    red_n_in = comb_n;
    red_d_in = dd;
    unique case (cmd.red_sel)
      2'd0: begin
        red_n_in = mag32(an);
        red_d_in = mag32(ad);
      end
      2'd1: begin
        red_n_in = mag32(bn);
        red_d_in = mag32(bd);
      end
      default: begin
        red_n_in = comb_n;
        red_d_in = dd;
      end
    endcase
  end

  rau_reducer u_red (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .num_in  (red_n_in),
    .den_in  (red_d_in),
    .done    (red_done),
    .num_out (red_n),
    .den_out (red_d)
  );

  assign red_start = cmd.red_start;
  assign dv_start = cmd.quo_start;

  rau_divider u_quo (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (red_n),
    .divisor  (red_d),
    .busy     (dv_busy),
    .quot     (dv_q),
    .rem      (dv_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy_d <= 1'b0;
    end else begin
      dv_busy_d <= dv_busy;
    end
  end

  assign sts.done = red_done || (dv_busy_d && !dv_busy);
  assign sts.err = (ad == '0) || (uses_b && bd == '0)
                 || (op_r == rau_pkg::OP_DIV && bn == '0);
  assign sts.skip_b = !uses_b;
  assign sts.is_cmp = (op_r == rau_pkg::OP_EQ) || (op_r == rau_pkg::OP_NE);
  assign sts.is_neg = (op_r == rau_pkg::OP_NEG);
  assign sts.is_quo = (op_r == rau_pkg::OP_QUO);

  assign sb = (b_n == '0) ? 1'b0 : ((op_r == rau_pkg::OP_SUB) ? !b_neg : b_neg);
  assign fit = (rn <= (r_neg ? Lim : Lim - 64'd1)) && (rd >= 64'd1) && (rd <= Lim - 64'd1);

  always_comb begin
    comb_n = x;
    comb_neg = a_neg ^ b_neg;
    priority if (op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV) begin
      comb_n = x;
      comb_neg = a_neg ^ b_neg;
    end else if (a_neg == sb) begin
      comb_n = x + y;
      comb_neg = a_neg;
    end else if (x >= y) begin
      comb_n = x - y;
      comb_neg = a_neg;
    end else begin
      comb_n = y - x;
      comb_neg = sb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
      a_neg <= a_num[31] ^ a_den[31];
      b_neg <= b_num[31] ^ b_den[31];
    end
    if (red_start) begin
      red_tgt <= cmd.red_sel;
    end
    if (red_done && red_tgt == 2'd0) begin
      a_n <= red_n;
      a_d <= red_d;
      if (red_n == '0) begin
        a_neg <= 1'b0;
      end
    end
    if (red_done && red_tgt == 2'd1) begin
      b_n <= red_n;
      b_d <= red_d;
      if (red_n == '0) begin
        b_neg <= 1'b0;
      end
    end
    if (red_done && red_tgt == 2'd2) begin
      rn <= red_n;
      rd <= red_d;
      if (red_n == '0) begin
        r_neg <= 1'b0;
      end
    end
    if (cmd.prod) begin
      unique case (op_r)
        rau_pkg::OP_MUL: begin
          x <= mul32(a_n[31:0], b_n[31:0]);
          y <= '0;
          dd <= mul32(a_d[31:0], b_d[31:0]);
        end
        rau_pkg::OP_DIV: begin
          x <= mul32(a_n[31:0], b_d[31:0]);
          y <= '0;
          dd <= mul32(a_d[31:0], b_n[31:0]);
        end
        default: begin
          x <= mul32(a_n[31:0], b_d[31:0]);
          y <= mul32(b_n[31:0], a_d[31:0]);
          dd <= mul32(a_d[31:0], b_d[31:0]);
        end
      endcase
    end
    if (cmd.comb) begin
      rd <= dd;
      rn <= comb_n;
      r_neg <= comb_neg;
    end
    if (red_done && red_tgt == 2'd0 && sts.is_neg) begin
      rn <= red_n;
      rd <= red_d;
      r_neg <= (red_n != '0) ? !a_neg : 1'b0;
    end
    if (dv_busy_d && !dv_busy) begin
      rn <= dv_q;
      rd <= 64'd1;
      r_neg <= (dv_q != '0) ? a_neg : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_num <= '0;
      res_den <= '0;
      cmp_flag <= 1'b0;
      priority if (sts.err) begin
        status <= rau_pkg::ST_ZERO;
      end else if (sts.is_cmp) begin
        status <= rau_pkg::ST_OK;
        cmp_flag <= ((a_neg == b_neg) && (a_n == b_n) && (a_d == b_d))
                    ^ (op_r == rau_pkg::OP_NE);
      end else if (!fit) begin
        status <= rau_pkg::ST_OVF;
      end else begin
        status <= rau_pkg::ST_OK;
        res_num <= r_neg ? (32'd0 - rn[31:0]) : rn[31:0];
        res_den <= rd[30:0];
      end
    end
  end

endmodule

### rtl/rau_ctrl.sv
module rau_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);

  rau_pkg::state_t state, state_next;
  logic [1:0] sel, sel_next;

  always_comb begin
    state_next = state;
    sel_next = sel;
    unique case (state)
      rau_pkg::S_IDLE: if (in_valid) state_next = rau_pkg::S_CHECK;
      rau_pkg::S_CHECK: begin
        sel_next = 2'd0;
        state_next = sts.err ? rau_pkg::S_FIN : rau_pkg::S_RED_A;
      end
      rau_pkg::S_RED_A: if (sts.done) begin
        if (sts.skip_b) begin
          state_next = sts.is_quo ? rau_pkg::S_QUO : rau_pkg::S_FIN;
        end else begin
          sel_next = 2'd1;
          state_next = rau_pkg::S_RED_B;
        end
      end
      rau_pkg::S_RED_B: if (sts.done) begin
        state_next = sts.is_cmp ? rau_pkg::S_FIN : rau_pkg::S_PROD;
      end
      rau_pkg::S_PROD: state_next = rau_pkg::S_COMB;
      rau_pkg::S_COMB: begin
        sel_next = 2'd2;
        state_next = rau_pkg::S_RED_R;
      end
      rau_pkg::S_RED_R: if (sts.done) state_next = rau_pkg::S_FIN;
      rau_pkg::S_QUO: if (sts.done) state_next = rau_pkg::S_FIN;
      rau_pkg::S_FIN: state_next = rau_pkg::S_OUT;
      rau_pkg::S_OUT: if (out_ready) state_next = rau_pkg::S_IDLE;
      default: state_next = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.red_sel = sel_next;
    in_ready = (state == rau_pkg::S_IDLE);
    out_valid = (state == rau_pkg::S_OUT);
    cmd.load = in_ready && in_valid;
    cmd.red_start = (state == rau_pkg::S_CHECK && !sts.err)
                 || (state == rau_pkg::S_RED_A && sts.done && !sts.skip_b)
                 || (state == rau_pkg::S_COMB);
    cmd.prod = (state == rau_pkg::S_PROD);
    cmd.comb = (state == rau_pkg::S_COMB);
    cmd.quo_start = (state == rau_pkg::S_RED_A && sts.done && sts.is_quo);
    cmd.fin = (state == rau_pkg::S_FIN);
    cmd.check = (state == rau_pkg::S_CHECK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
      sel <= 2'd0;
    end else begin
      state <= state_next;
      sel <= sel_next;
    end
  end

endmodule

### rtl/rational_arith_unit.sv
// Sequencing: a zero denominator goes straight to the result; otherwise each reduction runs
// the 64-step divider once per gcd remainder step plus twice for the divisions by the gcd.
// Throughput: one word at a time; the next word is taken after the result leaves.
// Reset: rst, synchronous, returns the controller to idle with no result pending.
module rational_arith_unit #(
  parameter int WORD_BITS = rau_pkg::WordBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               cmp_flag,
  output logic [1:0]         status
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .op       (op),
    .a_num    (a_num),
    .a_den    (a_den),
    .b_num    (b_num),
    .b_den    (b_den),
    .sts      (sts),
    .res_num  (res_num),
    .res_den  (res_den),
    .cmp_flag (cmp_flag),
    .status   (status)
  );

endmodule

### rtl/rau_checker.sv
module rau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] res_num,
  input logic [30:0]        res_den,
  input logic               cmp_flag,
  input logic [1:0]         status
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != rau_pkg::ST_OK)
      |-> (res_num == '0 && res_den == '0 && !cmp_flag))
    else $error("error result not cleared");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3)) else $error("bad status");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_num) && $stable(status)))
    else $error("result dropped");

endmodule

bind rational_arith_unit rau_checker u_chk (.*);
